FILE: rtl/mpu_rmt_pkg.sv
// Shared types and constants for the MPU region match table.
`timescale 1ns / 1ps
`default_nettype none

package mpu_rmt_pkg;

  localparam int REGIONS    = 8;
  localparam int IDX_W      = $clog2(REGIONS);
  localparam int ADDR_W     = 48;
  localparam int FLAG_W     = 5;
  localparam int ENABLE_BIT = 4;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [FLAG_W-1:0] flags_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_WRITE  = 1'b1
  } func_t;

  // Region update, applied when the request leaves the input stage.
  typedef struct packed {
    logic   en;
    idx_t   idx;
    addr_t  base;
    addr_t  mask;
    flags_t flags;
  } region_wr_t;

  // One request as held in the input stage.
  typedef struct packed {
    flags_t region_flags;
    addr_t  region_mask;
    addr_t  region_base;
    idx_t   region_index;
    func_t  func;
    addr_t  data_addr;
    addr_t  fetch_addr;
  } req_t;

  // Result word, fetch flags in the low bits.
  typedef struct packed {
    flags_t data_flags;
    flags_t fetch_flags;
  } rsp_t;

endpackage : mpu_rmt_pkg

`default_nettype wire

FILE: rtl/mpu_rmt_lookup.sv
// Priority match of one address against all regions; highest index wins.
`timescale 1ns / 1ps
`default_nettype none

module mpu_rmt_lookup (
  input  wire  mpu_rmt_pkg::addr_t  addr,
  input  wire  mpu_rmt_pkg::addr_t  base_tab  [mpu_rmt_pkg::REGIONS],
  input  wire  mpu_rmt_pkg::addr_t  mask_tab  [mpu_rmt_pkg::REGIONS],
  input  wire  mpu_rmt_pkg::flags_t flag_tab  [mpu_rmt_pkg::REGIONS],
  output logic [mpu_rmt_pkg::FLAG_W-1:0] flags
);
  import mpu_rmt_pkg::*;

  logic [REGIONS-1:0] hit;

  always_comb begin
    for (int i = 0; i < REGIONS; i++) begin
      hit[i] = flag_tab[i][ENABLE_BIT] && (base_tab[i] == (addr & mask_tab[i]));
    end
  end

  always_comb begin
    flags = '0;
    for (int i = 0; i < REGIONS; i++) begin
      if (hit[i]) begin
        flags = flag_tab[i];
      end
    end
  end

endmodule : mpu_rmt_lookup

`default_nettype wire

FILE: rtl/mpu_rmt_table.sv
// Region table storage with one write port and two lookup ports.
`timescale 1ns / 1ps
`default_nettype none

module mpu_rmt_table (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  mpu_rmt_pkg::region_wr_t wr,
  input  wire  mpu_rmt_pkg::addr_t     fetch_addr,
  input  wire  mpu_rmt_pkg::addr_t     data_addr,
  output logic [mpu_rmt_pkg::FLAG_W-1:0] fetch_flags,
  output logic [mpu_rmt_pkg::FLAG_W-1:0] data_flags
);
  import mpu_rmt_pkg::*;

  addr_t  base_r [REGIONS];
  addr_t  mask_r [REGIONS];
  flags_t flag_r [REGIONS];

  // A region written disabled stores all-ones base and mask.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REGIONS; i++) begin
        base_r[i] <= '0;
        mask_r[i] <= '0;
        flag_r[i] <= '1;
      end
    end else if (wr.en) begin
      if (wr.flags[ENABLE_BIT]) begin
        base_r[wr.idx] <= wr.base;
        mask_r[wr.idx] <= wr.mask;
      end else begin
        base_r[wr.idx] <= '1;
        mask_r[wr.idx] <= '1;
      end
      flag_r[wr.idx] <= wr.flags;
    end
  end

  mpu_rmt_lookup u_fetch (
    .addr     (fetch_addr),
    .base_tab (base_r),
    .mask_tab (mask_r),
    .flag_tab (flag_r),
    .flags    (fetch_flags)
  );

  mpu_rmt_lookup u_data (
    .addr     (data_addr),
    .base_tab (base_r),
    .mask_tab (mask_r),
    .flag_tab (flag_r),
    .flags    (data_flags)
  );

endmodule : mpu_rmt_table

`default_nettype wire

FILE: rtl/mpu_region_match_table.sv
// Top level of the MPU region match table: input stage, lookup, result register.
// Usage:
//   Each request on the in_ channel carries a fetch address and a data
//   address, plus an optional region update selected by in_tuser (func).
//   Both addresses are checked against the eight regions as they stood
//   before the request; the highest enabled matching region supplies the
//   flags, zero when none matches. The region update then takes effect
//   for all later requests.
//   Path: an accepted request is held in the input stage register, then its
//   result is captured in the result register that drives out_tvalid/out_tdata.
//   Throughput: one request per cycle while out_tready stays high; the path
//   from the input stage register through two parallel compare-and-priority
//   trees to the result register sets the cycle time.
//   Reset: rst_n low (synchronous) empties both stages and restores every
//   region to base 0, mask 0, all flags set, so every address matches.
//   Stall: while out_tready is low the result holds; one more request is
//   taken into the input stage, then in_tready drops until the result
//   is taken.
`timescale 1ns / 1ps
`default_nettype none

module mpu_region_match_table (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // fetch_addr[47:0], data_addr[95:48], region_index[98:96],
  // region_base[146:99], region_mask[194:147], region_flags[199:195]
  input  wire  [199:0] in_tdata,
  // func[0]
  input  wire  [0:0]   in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // fetch_flags[4:0], data_flags[9:5], zero pad [15:10]
  output logic [15:0]  out_tdata
);
  import mpu_rmt_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  req_t       s1_req_r;
  logic       out_valid_r, out_valid_nxt;
  rsp_t       out_rsp_r;
  logic       in_fire, s1_fire;
  region_wr_t wr;
  flags_t     fetch_flags, data_flags;
  req_t       in_req;

  // Unpack the incoming request.
  always_comb begin
    in_req.fetch_addr   = in_tdata[47:0];
    in_req.data_addr    = in_tdata[95:48];
    in_req.func         = func_t'(in_tuser[0]);
    in_req.region_index = in_tdata[98:96];
    in_req.region_base  = in_tdata[146:99];
    in_req.region_mask  = in_tdata[194:147];
    in_req.region_flags = in_tdata[199:195];
  end

  // Advance the input stage when the result register is free or draining.
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_req;
    end
    if (s1_fire) begin
      out_rsp_r.fetch_flags <= fetch_flags;
      out_rsp_r.data_flags  <= data_flags;
    end
  end

  // Commit the region update together with the lookup result, so later
  // requests see it and this one does not.
  always_comb begin
    wr.en    = s1_fire && (s1_req_r.func == FUNC_WRITE);
    wr.idx   = s1_req_r.region_index;
    wr.base  = s1_req_r.region_base;
    wr.mask  = s1_req_r.region_mask;
    wr.flags = s1_req_r.region_flags;
  end

  mpu_rmt_table u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr          (wr),
    .fetch_addr  (s1_req_r.fetch_addr),
    .data_addr   (s1_req_r.data_addr),
    .fetch_flags (fetch_flags),
    .data_flags  (data_flags)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_rsp_r};

  // A nonzero result always comes from an enabled region.
  a_fetch_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rsp_r.fetch_flags == '0 || out_rsp_r.fetch_flags[ENABLE_BIT]))
    else $error("fetch result from a disabled region");

  a_data_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rsp_r.data_flags == '0 || out_rsp_r.data_flags[ENABLE_BIT]))
    else $error("data result from a disabled region");

  // A held request moves on as soon as the result register is empty.
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("input stage did not advance into empty result register");

  // Region updates only happen when a request leaves the input stage.
  a_write_gated: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (s1_valid_r && (!out_valid_r || out_tready)))
    else $error("region write without a request moving");

endmodule : mpu_region_match_table

`default_nettype wire
